@@ sv/two_layer_crossfade_sequencer_defines.svh @@
// Assertion macros for the crossfade sequencer checker.
// Depends on nothing; include by bare file name.
`ifndef TWO_LAYER_CROSSFADE_SEQUENCER_DEFINES_SVH
`define TWO_LAYER_CROSSFADE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tlcs_pkg.sv @@
// Shared types and constants of the two-layer crossfade sequencer.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package tlcs_pkg;

    localparam int unsigned MAX_IMAGES = 256;

    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;
    localparam int CNT_W     = 9;
    localparam int IMG_W     = 8;
    localparam int LEVEL_W   = 8;
    localparam int CFG_IDX_W = 8;
    localparam int STEP_W    = $clog2(LEVEL_W);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    localparam logic [DUR_W-1:0] FADE_DUR_RST    = 16'd500;
    localparam logic [DUR_W-1:0] SHOW_DUR_RST    = 16'd1000;
    localparam logic [CNT_W-1:0] IMAGE_COUNT_RST = 9'd1;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_BEGIN  = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_DONE   = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_DUR    = 8'd0,
        CFG_SHOW_DUR    = 8'd1,
        CFG_IMAGE_COUNT = 8'd2,
        CFG_FIRST_START = 8'd3
    } t_cfg_index;

    typedef struct packed {
        logic latch_in;
        logic eval;
        logic prep;
        logic setup;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_div;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ sv/tlcs_ctrl.sv @@
// Sequencing controller of the crossfade sequencer: walks one request through
// evaluate, prepare, setup when a fade level is needed, eight divide steps and output load. Uses tlcs_pkg.
`default_nettype none

module tlcs_ctrl
    import tlcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PREP,
        S_SETUP,
        S_DIV,
        S_FIN
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                // skip the divider when the tick neither starts nor runs a fade
                n_state = i_status.needs_div ? S_SETUP : S_FIN;
            end
            S_SETUP: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                if (r_step == STEP_W'(LEVEL_W - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.latch_in = (r_state == S_IDLE) && i_in_valid;
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.setup    = (r_state == S_SETUP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_FIN) && i_status.out_free;
    end

endmodule

`default_nettype wire

@@ sv/tlcs_dp.sv @@
// Datapath of the crossfade sequencer: configuration and schedule registers,
// restoring fade-level divider and the output register. Uses tlcs_pkg.
`default_nettype none

module tlcs_dp
    import tlcs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_status,
    input  wire logic [TIME_W-1:0]    i_now_ms,
    input  wire logic                 i_cfg_fire,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TIME_W-1:0]    i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_action,
    output logic                      o_fade_layer,
    output logic [LEVEL_W-1:0]        o_fade_level,
    output logic [IMG_W-1:0]          o_assigned_image,
    output logic                      o_hidden_layer,
    output logic [1:0]                o_layers_up
);

    // configuration and schedule state
    logic [DUR_W-1:0]   r_fade_dur;
    logic [DUR_W-1:0]   r_show_dur;
    logic [CNT_W-1:0]   r_image_count;
    logic [TIME_W-1:0]  r_wait_start;
    logic [TIME_W-1:0]  r_fade_end;
    logic               r_incoming;
    logic [IMG_W-1:0]   r_image_counter;
    logic [1:0]         r_shown;

    // per-request working registers
    t_action            r_act;
    logic [TIME_W-1:0]  r_now;
    logic               r_flayer;
    logic [IMG_W-1:0]   r_img;
    logic               r_hidden;
    logic [TIME_W-1:0]  r_elapsed;
    logic [TIME_W-1:0]  r_span;
    logic [TIME_W-1:0]  r_rem;
    logic [LEVEL_W-1:0] r_dlow;
    logic [LEVEL_W-1:0] r_quot;
    logic               r_sat;

    // output register
    logic               r_out_valid;
    t_action            r_out_action;
    logic               r_out_flayer;
    logic [LEVEL_W-1:0] r_out_level;
    logic [IMG_W-1:0]   r_out_img;
    logic               r_out_hidden;
    logic [1:0]         r_out_up;

    logic                      w_due;
    logic [TIME_W-1:0]         w_fade_end_new;
    logic [TIME_W-1:0]         w_resume;
    logic [CNT_W-1:0]          w_next;
    logic                      w_wrap;
    logic [TIME_W+LEVEL_W-1:0] w_scaled;
    logic [TIME_W:0]           w_trial;
    logic [TIME_W:0]           w_diff;
    logic                      w_ge;
    logic                      w_has_level;

    assign w_due          = (r_wait_start != '0) && (r_now >= r_wait_start);
    assign w_fade_end_new = r_wait_start + {{(TIME_W-DUR_W){1'b0}}, r_fade_dur};
    assign w_resume       = r_now + {{(TIME_W-DUR_W){1'b0}}, r_show_dur};
    assign w_next         = {1'b0, r_image_counter} + CNT_W'(1);
    assign w_wrap         = (w_next >= r_image_count)
                         || ({{(32-CNT_W){1'b0}}, w_next} >= MAX_IMAGES)
                         || (w_next > CNT_W'(255));

    // 255 * elapsed as (elapsed << 8) - elapsed
    assign w_scaled = {r_elapsed, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, r_elapsed};

    // one restoring step: the remainder stays below the span
    assign w_trial = {r_rem, r_dlow[LEVEL_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_span});
    assign w_diff  = w_trial - {1'b0, r_span};

    assign w_has_level = (r_act == ACT_BEGIN) || (r_act == ACT_UPDATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_dur      <= FADE_DUR_RST;
            r_show_dur      <= SHOW_DUR_RST;
            r_image_count   <= IMAGE_COUNT_RST;
            r_wait_start    <= '0;
            r_fade_end      <= '0;
            r_incoming      <= 1'b0;
            r_image_counter <= '0;
            r_shown         <= '0;
            r_act           <= ACT_NONE;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_fire) begin
                case (i_cfg_index)
                    CFG_FADE_DUR:    r_fade_dur    <= i_cfg_data[DUR_W-1:0];
                    CFG_SHOW_DUR:    r_show_dur    <= i_cfg_data[DUR_W-1:0];
                    CFG_IMAGE_COUNT: r_image_count <= i_cfg_data[CNT_W-1:0];
                    CFG_FIRST_START: r_wait_start  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.eval) begin
                r_act <= ACT_NONE;
                if (w_due) begin
                    if (r_fade_end == '0) begin
                        // fade begins: hand the next image to the incoming layer
                        r_act              <= ACT_BEGIN;
                        r_fade_end         <= w_fade_end_new;
                        r_image_counter    <= w_wrap ? '0 : w_next[IMG_W-1:0];
                        r_shown[r_incoming] <= 1'b1;
                    end else if (r_now > r_fade_end) begin
                        // fade done: schedule the next start and swap layers
                        r_act               <= ACT_DONE;
                        r_wait_start        <= w_resume;
                        r_fade_end          <= '0;
                        r_incoming          <= ~r_incoming;
                        r_shown[~r_incoming] <= 1'b0;
                    end else begin
                        r_act <= ACT_UPDATE;
                    end
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_now <= i_now_ms;
        end

        if (i_cmd.eval) begin
            r_flayer <= w_due && r_incoming;
            r_img    <= (w_due && (r_fade_end == '0)) ? r_image_counter : '0;
            r_hidden <= w_due && (r_fade_end != '0) && (r_now > r_fade_end) && !r_incoming;
        end

        if (i_cmd.prep) begin
            r_elapsed <= r_now - r_wait_start;
            r_span    <= r_fade_end - r_wait_start;
        end

        if (i_cmd.setup) begin
            // elapsed at or past the span saturates the level at zero
            r_sat  <= (r_span == '0) || (r_elapsed >= r_span);
            r_rem  <= w_scaled[TIME_W+LEVEL_W-1:LEVEL_W];
            r_dlow <= w_scaled[LEVEL_W-1:0];
            r_quot <= '0;
        end

        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
            r_quot <= {r_quot[LEVEL_W-2:0], w_ge};
            r_dlow <= {r_dlow[LEVEL_W-2:0], 1'b0};
        end

        if (i_cmd.load_out) begin
            r_out_action <= r_act;
            r_out_flayer <= r_flayer;
            r_out_level  <= (w_has_level && !r_sat) ? (LEVEL_MAX - r_quot) : '0;
            r_out_img    <= r_img;
            r_out_hidden <= r_hidden;
            r_out_up     <= r_shown;
        end
    end

    assign o_status.needs_div = w_has_level;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_out_action;
    assign o_fade_layer     = r_out_flayer;
    assign o_fade_level     = r_out_level;
    assign o_assigned_image = r_out_img;
    assign o_hidden_layer   = r_out_hidden;
    assign o_layers_up      = r_out_up;

endmodule

`default_nettype wire

@@ sv/two_layer_crossfade_sequencer.sv @@
// Top level of the two-layer crossfade sequencer.
// Depends on tlcs_pkg, tlcs_ctrl and tlcs_dp.
//   Input channel (i_in_valid / o_in_ready) carries one timer tick, i_now_ms.
//   Every accepted request yields exactly one result on the output channel
//   (o_out_valid / i_out_ready): action, fade layer and level, assigned
//   image, hidden layer and the shown-layer mask after the tick.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; index 0 fade
//   duration, 1 show duration, 2 image count, 3 first start (loads the wait
//   start). Other indexes are dropped. Write only while no request is open.
// Sequence:
//   A tick that starts or runs a fade passes evaluate, prepare, setup, the
//   divide steps and output load; the fade level comes from an 8-step
//   restoring divider, one quotient bit per cycle. Other ticks go from
//   prepare straight to output load. The next tick is taken while a result
//   still waits in the output register.
// Reset and stall:
//   Synchronous active-low reset restores the configuration defaults and
//   idles the schedule (wait start 0). If the receiver stalls, the finished
//   request holds in the output register and the controller waits before
//   loading the next result.
`default_nettype none

module two_layer_crossfade_sequencer
    import tlcs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [TIME_W-1:0]    i_now_ms,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_action,
    output logic                      o_fade_layer,
    output logic [LEVEL_W-1:0]        o_fade_level,
    output logic [IMG_W-1:0]          o_assigned_image,
    output logic                      o_hidden_layer,
    output logic [1:0]                o_layers_up,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TIME_W-1:0]    i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    tlcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tlcs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_now_ms         (i_now_ms),
        .i_cfg_fire       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_action         (o_action),
        .o_fade_layer     (o_fade_layer),
        .o_fade_level     (o_fade_level),
        .o_assigned_image (o_assigned_image),
        .o_hidden_layer   (o_hidden_layer),
        .o_layers_up      (o_layers_up)
    );

endmodule

`default_nettype wire

@@ sv/tlcs_checker.sv @@
// Port-level checker of the crossfade sequencer, bound to the top level.
// Depends on tlcs_pkg and two_layer_crossfade_sequencer_defines.svh.
`default_nettype none

`include "two_layer_crossfade_sequencer_defines.svh"

module tlcs_checker
    import tlcs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [1:0]           o_action,
    input wire logic                 o_fade_layer,
    input wire logic [LEVEL_W-1:0]   o_fade_level,
    input wire logic [IMG_W-1:0]     o_assigned_image,
    input wire logic                 o_hidden_layer,
    input wire logic [1:0]           o_layers_up
);

    // a stalled result holds
    `TLCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_action) && $stable(o_fade_level) && $stable(o_layers_up),
        "result changed while stalled")

    // an idle tick reports no layer, level, image or hidden layer
    `TLCS_ASSERT_NOW(a_idle_zero, i_clk, i_rst_n, o_out_valid && (o_action == ACT_NONE),
        !o_fade_layer && (o_fade_level == '0) && (o_assigned_image == '0) && !o_hidden_layer,
        "idle tick with nonzero fields")

    // a starting fade shows its layer
    `TLCS_ASSERT_NOW(a_begin_shown, i_clk, i_rst_n, o_out_valid && (o_action == ACT_BEGIN),
        o_fade_layer ? o_layers_up[1] : o_layers_up[0],
        "fade layer not shown at fade start")

    // a finished fade hides the other layer and reports a zero level
    `TLCS_ASSERT_NOW(a_done_hide, i_clk, i_rst_n, o_out_valid && (o_action == ACT_DONE),
        (o_hidden_layer != o_fade_layer) && (o_fade_level == '0)
            && !(o_hidden_layer ? o_layers_up[1] : o_layers_up[0]),
        "fade done without hiding the other layer")

endmodule

bind two_layer_crossfade_sequencer tlcs_checker u_tlcs_checker (.*);

`default_nettype wire
